@@ hw/rtl/text_width_estimator_assert.svh @@
// Assertion macros for the text width estimator checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef TEXT_WIDTH_ESTIMATOR_ASSERT_SVH
`define TEXT_WIDTH_ESTIMATOR_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define TWE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TWE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hw/rtl/twe_pkg.sv @@
// Shared types, constants and the byte classifier of the text width estimator.
// No dependencies; used by the front end, queue, back end and top level.
package twe_pkg;

   // Accumulator, result, scaled, font and glyph widths.
   localparam int ACC_W    = 24;
   localparam int OUT_W    = 24;
   localparam int SCALED_W = 40;
   localparam int FONT_W   = 16;
   localparam int WID_W    = 7;

   localparam logic [ACC_W-1:0]  ACC_MAX    = '1;
   localparam logic [OUT_W-1:0]  OUT_MAX    = '1;
   localparam logic [FONT_W-1:0] FONT_RESET = 16'd4096;

   // Glyph widths in hundredths of an em.
   localparam logic [WID_W-1:0] W_SPACE = 7'd31;
   localparam logic [WID_W-1:0] W_DIGIT = 7'd53;
   localparam logic [WID_W-1:0] W_UPPER = 7'd61;
   localparam logic [WID_W-1:0] W_LOWER = 7'd48;
   localparam logic [WID_W-1:0] W_OTHER = 7'd34;
   localparam logic [WID_W-1:0] W_MULTI = 7'd96;

   // Character codes and UTF-8 lead byte patterns.
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] LEAD2      = 8'hC0;
   localparam logic [7:0] LEAD3      = 8'hE0;
   localparam logic [7:0] LEAD4      = 8'hF0;

   // Token queue between the classifier and the accumulator.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // One classified byte: width to add, line break and end of text.
   typedef struct packed {
      logic [WID_W-1:0] wid;
      logic             newline;
      logic             last;
   } token_type;

   // Width of a single-byte ASCII glyph other than newline.
   function automatic logic [WID_W-1:0] ascii_width(input logic [7:0] c);
      logic [WID_W-1:0] w;
      if (c == CH_SPACE) begin
         w = W_SPACE;
      end else if (c inside {[8'h30:8'h39]}) begin
         w = W_DIGIT;
      end else if (c inside {[8'h41:8'h5A]}) begin
         w = W_UPPER;
      end else if (c inside {[8'h61:8'h7A]}) begin
         w = W_LOWER;
      end else begin
         w = W_OTHER;
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/twe_front.sv @@
// Front end of the text width estimator: accepts bytes, tracks UTF-8 skips
// and turns each word into a token. Depends on twe_pkg.
module twe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] text_byte
   input  logic [0:0]          req_tuser,   // [0] byte_present
   input  logic                req_tlast,   // last_byte
   input  logic                fifo_full,
   output logic                push_valid,
   output twe_pkg::token_type  push_token
);

   logic [1:0] skip_ff;
   logic [1:0] skip_in;
   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = !fifo_full;
   assign push_valid = req_tvalid && req_tready;

   // Classify the byte and work out the continuation bytes still to skip.
   always_comb begin
      push_token      = '0;
      push_token.last = req_tlast;
      skip_in         = skip_ff;
      if (req_tuser[0]) begin
         if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (c == twe_pkg::CH_NEWLINE) begin
            push_token.newline = 1'b1;
         end else if (!c[7]) begin
            push_token.wid = twe_pkg::ascii_width(c);
         end else begin
            push_token.wid = twe_pkg::W_MULTI;
            if ((c & twe_pkg::MASK_LEAD2) == twe_pkg::LEAD2) begin
               skip_in = 2'd1;
            end else if ((c & twe_pkg::MASK_LEAD3) == twe_pkg::LEAD3) begin
               skip_in = 2'd2;
            end else if ((c & twe_pkg::MASK_LEAD4) == twe_pkg::LEAD4) begin
               skip_in = 2'd3;
            end else begin
               skip_in = 2'd0;
            end
         end
      end
      // A text that ends inside a sequence drops the pending skip.
      if (req_tlast) begin
         skip_in = 2'd0;
      end
   end

   // Skip counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 2'd0;
      end else if (push_valid) begin
         skip_ff <= skip_in;
      end
   end

endmodule

@@ hw/rtl/twe_fifo.sv @@
// Short token queue between the front end and the accumulator back end.
// Depends on twe_pkg.
module twe_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  twe_pkg::token_type  push_token,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output twe_pkg::token_type  pop_token
);

   twe_pkg::token_type                mem_ff [twe_pkg::FIFO_DEPTH];
   logic [twe_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [twe_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [twe_pkg::FIFO_CNT_W-1:0]    count_ff;
   logic                              do_push;
   logic                              do_pop;

   assign full      = count_ff == twe_pkg::FIFO_CNT_W'(twe_pkg::FIFO_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_token = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

@@ hw/rtl/twe_back.sv @@
// Back end of the text width estimator: line accumulation, widest line,
// result clamp and font scaling into the output register. Depends on twe_pkg.
module twe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  twe_pkg::token_type  tok,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,   // [23:0] max_line_centiem, [63:24] width_scaled
   output logic [0:0]          rsp_tuser    // [0] saturated
);

   localparam int ACC_W = twe_pkg::ACC_W;
   localparam int OUT_W = twe_pkg::OUT_W;
   localparam int SC_W  = twe_pkg::SCALED_W;

   logic [ACC_W-1:0]          line_ff;
   logic [ACC_W-1:0]          widest_ff;
   logic                      ovf_ff;
   logic [twe_pkg::FONT_W-1:0] font_ff;

   logic                      s1_valid_ff;
   logic [OUT_W-1:0]          s1_max_ff;
   logic                      s1_sat_ff;

   logic                      rsp_valid_ff;
   logic [OUT_W-1:0]          rsp_max_ff;
   logic [SC_W-1:0]           rsp_scaled_ff;
   logic                      rsp_sat_ff;

   logic [ACC_W:0]            sum;
   logic                      add_ovf;
   logic [ACC_W-1:0]          added;
   logic [ACC_W-1:0]          line_in;
   logic [ACC_W-1:0]          widest_in;
   logic [ACC_W-1:0]          final_w;
   logic [SC_W-1:0]           final_ext;
   logic [OUT_W-1:0]          clamp_w;
   logic                      clamp_sat;
   logic                      s1_ready;
   logic                      s2_ready;
   logic                      pop;
   logic                      s1_take;
   logic [SC_W-1:0]           product;

   assign csr_ready  = 1'b1;
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign tok_ready  = !tok.last || s1_ready;
   assign pop        = tok_valid && tok_ready;
   assign s1_take    = s1_valid_ff && s2_ready;

   // Saturating add of the glyph width, then the line fold on a newline.
   always_comb begin
      sum     = {1'b0, line_ff} + (ACC_W + 1)'(tok.wid);
      add_ovf = sum[ACC_W];
      added   = add_ovf ? twe_pkg::ACC_MAX : sum[ACC_W-1:0];
      if (tok.newline) begin
         line_in   = '0;
         widest_in = (line_ff > widest_ff) ? line_ff : widest_ff;
      end else begin
         line_in   = added;
         widest_in = widest_ff;
      end
      final_w = (line_in > widest_in) ? line_in : widest_in;
   end

   // Clamp the widest line to the result width.
   always_comb begin
      final_ext = SC_W'(final_w);
      if (final_ext > SC_W'(twe_pkg::OUT_MAX)) begin
         clamp_w   = twe_pkg::OUT_MAX;
         clamp_sat = 1'b1;
      end else begin
         clamp_w   = final_ext[OUT_W-1:0];
         clamp_sat = ovf_ff || add_ovf;
      end
   end

   // Scale by the font size; 24 by 16 bits fits the 40-bit result exactly.
   assign product = SC_W'(s1_max_ff) * SC_W'(font_ff);

   // Control state: accumulators, font register and stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         widest_ff    <= '0;
         ovf_ff       <= 1'b0;
         font_ff      <= twe_pkg::FONT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            font_ff <= csr_data;
         end
         if (pop) begin
            if (tok.last) begin
               line_ff   <= '0;
               widest_ff <= '0;
               ovf_ff    <= 1'b0;
            end else begin
               line_ff   <= line_in;
               widest_ff <= widest_in;
               ovf_ff    <= ovf_ff || add_ovf;
            end
         end
         if (pop && tok.last) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_take) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (pop && tok.last) begin
         s1_max_ff <= clamp_w;
         s1_sat_ff <= clamp_sat;
      end
      if (s1_take) begin
         rsp_max_ff    <= s1_max_ff;
         rsp_scaled_ff <= product;
         rsp_sat_ff    <= s1_sat_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_scaled_ff, rsp_max_ff};
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule

@@ hw/rtl/text_width_estimator.sv @@
// Text width estimator: UTF-8 byte stream in, widest line width out.
// Instantiates twe_front, twe_fifo and twe_back; depends on twe_pkg.
//
// Usage:
//   The req channel takes one text byte per word: tdata holds the byte,
//   tuser[0] says whether the byte is real (0 marks an empty text) and tlast
//   marks the final byte of a text. Each text yields one rsp word when its
//   last byte is taken: tdata[23:0] is the widest line in hundredths of an
//   em, tdata[63:24] that width times the font size (unit 1/25600 pixel),
//   tuser[0] flags a saturated accumulator.
//   The csr channel writes the font size (unsigned 8.8); it is always ready
//   and should be written only while no text is in flight.
// Timing:
//   One byte per cycle while the queue has room. The front end classifies a byte
//   in the cycle it is accepted and pushes a token into a four-entry queue; the
//   back end retires one token per cycle unless a last token waits. The result
//   goes through the queue, then the accumulate and scale registers, to rsp.
// Reset and stall:
//   Reset clears all line state, empties the queue and restores the font
//   size to 16.0 px. A stalled rsp holds its word; req keeps taking bytes
//   until the queue fills and a further last token waits in the back end.
module text_width_estimator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // last_byte
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,    // font_size_q8
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [23:0] max_line_centiem, [63:24] width_scaled
   output logic [0:0]  rsp_tuser    // [0] saturated
);

   logic               push_valid;
   twe_pkg::token_type push_token;
   logic               fifo_full;
   logic               pop_valid;
   logic               pop_ready;
   twe_pkg::token_type pop_token;

   // Byte classification.
   twe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_token (push_token)
   );

   // Token queue.
   twe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .full       (fifo_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_token  (pop_token)
   );

   // Accumulation and result.
   twe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (pop_valid),
      .tok_ready  (pop_ready),
      .tok        (pop_token),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hw/rtl/twe_checker.sv @@
// Port-level checker for the text width estimator, bound to the top level.
// Depends on text_width_estimator_assert.svh.
`include "text_width_estimator_assert.svh"

module twe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A stalled result word stays offered and unchanged.
   `TWE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp word dropped")
   `TWE_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed")

   // A zero width always scales to zero.
   `TWE_ASSERT(a_zero_scale, rsp_tvalid && rsp_tdata[23:0] == 24'd0 |-> rsp_tdata[63:24] == 40'd0, "nonzero scaled width")

   // No result is offered in the cycle after reset.
   `TWE_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

endmodule

bind text_width_estimator twe_checker u_twe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_text_width_estimator.sv @@
// Self-checking testbench for the text width estimator.
// Needs only the RTL (text_width_estimator and its submodules); keeps its own
// line-width predictor and checks each result word against it.
module tb_text_width_estimator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 8;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_CYCLES     = 80;
   localparam int LONG_LINE_BYTES = 100;
   localparam int MAX_PRINTED     = 30;

   // Glyph widths in hundredths of an em.
   localparam logic [6:0] CEM_SPACE = 7'd31;
   localparam logic [6:0] CEM_DIGIT = 7'd53;
   localparam logic [6:0] CEM_UPPER = 7'd61;
   localparam logic [6:0] CEM_LOWER = 7'd48;
   localparam logic [6:0] CEM_OTHER = 7'd34;
   localparam logic [6:0] CEM_MULTI = 7'd96;

   localparam logic [23:0] LINE_CEIL    = 24'hFFFFFF;
   localparam logic [15:0] FONT_DEFAULT = 16'd4096;
   localparam logic [15:0] FONT_MAX     = 16'hFFFF;

   // Byte codes and UTF-8 lead patterns.
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_STRAY   = 8'hFF;
   localparam logic [7:0] BYTE_LOWER_A = 8'h61;
   localparam logic [7:0] BYTE_LOWER_Q = 8'h71;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD4_MASK   = 8'hF8;
   localparam logic [7:0] LEAD2_CODE   = 8'hC0;
   localparam logic [7:0] LEAD3_CODE   = 8'hE0;
   localparam logic [7:0] LEAD4_CODE   = 8'hF0;
   localparam logic [7:0] CONT_CODE    = 8'h80;

   typedef struct {
      logic [23:0] max_line;
      logic [39:0] scaled;
      logic        sat;
   } text_result_type;

   typedef struct {
      logic [7:0] value;
      logic       present;
   } text_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] text_byte
   logic [0:0]  req_tuser;   // [0] byte_present
   logic        req_tlast;   // last_byte
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;    // font_size_q8
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [23:0] max_line_centiem, [63:24] width_scaled
   logic [0:0]  rsp_tuser;   // [0] saturated

   // Predictor state: open line, widest line, bytes to skip, ceiling flag, font.
   logic [23:0] line_cem;
   logic [23:0] widest_cem;
   logic [1:0]  skip_left;
   logic        ceiling_hit;
   logic [15:0] font_q8;

   text_result_type result_q[$];
   text_word_type   text_buf[$];

   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_request  = 1'b0;
   int error_count   = 0;
   int word_count    = 0;
   int text_count    = 0;
   int font_count    = 0;
   int checked_count = 0;

   text_width_estimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock, 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Width of one classified glyph; anything from 0x80 up counts as multibyte.
   function automatic logic [6:0] glyph_width(input logic [7:0] c);
      if (c == BYTE_SPACE) begin
         return CEM_SPACE;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         return CEM_DIGIT;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         return CEM_UPPER;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         return CEM_LOWER;
      end else if (c < 8'h80) begin
         return CEM_OTHER;
      end
      return CEM_MULTI;
   endfunction

   // Saturating add into the open line.
   function automatic void add_glyph(input logic [6:0] w);
      logic [24:0] sum;
      sum = {1'b0, line_cem} + 25'(w);
      if (sum > {1'b0, LINE_CEIL}) begin
         line_cem    = LINE_CEIL;
         ceiling_hit = 1'b1;
      end else begin
         line_cem = sum[23:0];
      end
   endfunction

   function automatic void fold_line();
      if (line_cem > widest_cem) widest_cem = line_cem;
      line_cem = '0;
   endfunction

   function automatic void clear_text();
      line_cem    = '0;
      widest_cem  = '0;
      skip_left   = '0;
      ceiling_hit = 1'b0;
   endfunction

   // Advances the predictor by one accepted word; a last word queues a result.
   function automatic void estimate_word(input logic [7:0] c, input logic present,
                                         input logic last);
      text_result_type r;
      if (present) begin
         if (skip_left != 2'd0) begin
            skip_left = skip_left - 2'd1;
         end else if (c == BYTE_NEWLINE) begin
            fold_line();
         end else begin
            add_glyph(glyph_width(c));
            if ((c & LEAD2_MASK) == LEAD2_CODE) begin
               skip_left = 2'd1;
            end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
               skip_left = 2'd2;
            end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
               skip_left = 2'd3;
            end
         end
      end
      if (last) begin
         fold_line();
         r.max_line = widest_cem;
         r.scaled   = {16'd0, widest_cem} * {24'd0, font_q8};
         r.sat      = ceiling_hit;
         result_q.insert(result_q.size(), r);
         clear_text();
         text_count++;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   // Compares every accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      text_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            report_mismatch("result word with no text pending", rsp_tdata, 64'd0);
         end else begin
            want = result_q.pop_front();
            checked_count++;
            if (rsp_tdata[23:0] !== want.max_line)
               report_mismatch("max_line_centiem", 64'(rsp_tdata[23:0]), 64'(want.max_line));
            if (rsp_tdata[63:24] !== want.scaled)
               report_mismatch("width_scaled", 64'(rsp_tdata[63:24]), 64'(want.scaled));
            if (rsp_tuser[0] !== want.sat)
               report_mismatch("saturated", 64'(rsp_tuser[0]), 64'(want.sat));
         end
      end
   end

   // Result receiver: random stall bursts, plus a long hold on request.
   initial begin : drive_rsp_ready
      int gap_left;
      int hold_left;
      gap_left   = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one word, waits for the handshake, then updates the predictor.
   task automatic send_word(input logic [7:0] value, input logic present, input logic last);
      int gap;
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid   <= 1'b1;
      req_tdata    <= value;
      req_tuser[0] <= present;
      req_tlast    <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      estimate_word(value, present, last);
      word_count++;
   endtask

   task automatic release_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Waits until every expected result has come, then lets the pipeline settle.
   task automatic wait_for_results();
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Font size writes happen only with no text in flight.
   task automatic write_font(input logic [15:0] value);
      release_sender();
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      font_q8 = value;
      font_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void push_word(input logic [7:0] value, input logic present);
      text_word_type w;
      w.value   = value;
      w.present = present;
      text_buf.insert(text_buf.size(), w);
   endfunction

   // Continuation byte; now and then an arbitrary byte to break the sequence.
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return CONT_CODE | 8'($urandom_range(0, 63));
   endfunction

   // Builds one text: mostly well-formed UTF-8 with newlines, some noise,
   // cut-off sequences and absent words.
   task automatic build_random_text(input int max_len);
      int target;
      int kind;
      int k;
      text_buf.delete();
      if ($urandom_range(0, 29) == 0) begin
         push_word(8'($urandom_range(0, 255)), 1'b0);
         return;
      end
      target = $urandom_range(1, max_len);
      while (text_buf.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            push_word(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
         end else if (kind < 58) begin
            push_word(BYTE_NEWLINE, 1'b1);
         end else if (kind < 68) begin
            push_word(8'($urandom_range(8'hC2, 8'hDF)), 1'b1);
            push_word(cont_byte(), 1'b1);
         end else if (kind < 76) begin
            push_word(8'($urandom_range(8'hE0, 8'hEF)), 1'b1);
            for (k = 0; k < 2; k++) push_word(cont_byte(), 1'b1);
         end else if (kind < 82) begin
            push_word(8'($urandom_range(8'hF0, 8'hF7)), 1'b1);
            for (k = 0; k < 3; k++) push_word(cont_byte(), 1'b1);
         end else if (kind < 90) begin
            push_word(8'($urandom_range(0, 255)), 1'b1);
         end else if (kind < 94) begin
            push_word(8'($urandom_range(8'hC0, 8'hF7)), 1'b1);
         end else begin
            push_word(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic send_buffered_text();
      foreach (text_buf[i]) begin
         send_word(text_buf[i].value, text_buf[i].present, i == text_buf.size() - 1);
      end
   endtask

   // Every glyph class at its range ends, newline handling, multibyte skips,
   // stray bytes, an absent word inside a sequence and a text cut mid-sequence.
   task automatic test_directed();
      logic [7:0] plain[11] = '{8'h20, 8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A,
                                8'h00, 8'h7F, 8'h0A, 8'h7E};
      logic [7:0] multi[15] = '{8'hC3, 8'h0A, 8'hE2, 8'h82, 8'hFF, 8'hAC, 8'hF0, 8'h9F,
                                8'h98, 8'h80, 8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hF4};
      // Empty text at the reset font size.
      send_word(8'h00, 1'b0, 1'b1);
      foreach (plain[i]) send_word(plain[i], 1'b1, i == 10);
      // The fifth word is absent and must not use up a pending skip.
      foreach (multi[i]) send_word(multi[i], i != 4, i == 14);
      // The previous text ended inside a sequence; this one starts clean and
      // ends on a newline.
      send_word(BYTE_LOWER_Q, 1'b1, 1'b0);
      send_word(BYTE_NEWLINE, 1'b1, 1'b1);
   endtask

   // Short texts at the font size extremes and a few in between.
   task automatic test_font_extremes();
      logic [15:0] sizes[5] = '{16'h0000, FONT_MAX, 16'h0001, 16'h0100, 16'h8000};
      foreach (sizes[i]) begin
         write_font(sizes[i]);
         repeat (4) begin
            build_random_text(12);
            send_buffered_text();
         end
      end
   endtask

   // The receiver holds off while short texts keep coming, so the queue fills
   // and the input stalls.
   task automatic test_backpressure();
      sender_idle  = 1'b0;
      hold_request = 1'b1;
      repeat (30) begin
         build_random_text(3);
         send_buffered_text();
      end
      sender_idle = 1'b1;
   endtask

   // Random texts with a fresh font size every couple dozen texts.
   task automatic test_random_texts(input int word_goal);
      int first_word;
      int since_font;
      first_word = word_count;
      since_font = 0;
      while (word_count - first_word < word_goal) begin
         if (since_font == 25) begin
            since_font = 0;
            if ($urandom_range(0, 3) == 0) begin
               write_font($urandom_range(0, 1) ? FONT_MAX : 16'h0000);
            end else begin
               write_font(16'($urandom_range(0, 65535)));
            end
         end
         build_random_text($urandom_range(0, 7) == 0 ? 60 : 16);
         send_buffered_text();
         since_font++;
      end
   endtask

   // One long line of wide stray bytes at the largest font size.
   task automatic test_long_line();
      write_font(FONT_MAX);
      repeat (LONG_LINE_BYTES) send_word(BYTE_STRAY, 1'b1, 1'b0);
      send_word(BYTE_LOWER_A, 1'b1, 1'b1);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      font_q8    = FONT_DEFAULT;
      clear_text();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_font_extremes();
      test_backpressure();
      test_random_texts(680);
      // Last stretch runs at full rate on both sides.
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      test_random_texts(120);
      test_long_line();
      release_sender();
      wait_for_results();

      $display("Run covered %0d texts in %0d words over %0d font sizes; %0d results checked.",
               text_count, word_count, font_count, checked_count);
      $display("It included a receiver hold with the input stalled and a long single line.");
      if (error_count == 0) begin
         $display("text_width_estimator: match");
      end else begin
         $display("text_width_estimator: mismatch");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2500000;
      $display("Timeout with %0d results still pending.", result_q.size());
      $display("text_width_estimator: mismatch");
      $finish;
   end

endmodule
